// ----- design/tpdt_pkg.sv -----
// Package for the tolerant point deduplication table.
// Holds table sizes, coordinate helpers and the transfer payload types.
// No dependencies.
package tpdt_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 32;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int DIFF_W = (COORD_BITS + 1 > 32) ? COORD_BITS + 1 : 32;
	localparam int IN_COORD_W = 32;
	localparam int POINT_INDEX_W = 10;
	localparam int UNIQUE_COUNT_W = 11;
	localparam int DIMS_W = 2;
	localparam int TOL_W = 31;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIMS_IN_USE = 1'b0,
		REG_MATCH_TOL = 1'b1
	} cfg_reg_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} coord_pt_t;

	typedef struct packed {
		logic new_mesh;
		logic signed [IN_COORD_W-1:0] coord_x;
		logic signed [IN_COORD_W-1:0] coord_y;
		logic signed [IN_COORD_W-1:0] coord_z;
	} point_in_t;

	typedef struct packed {
		logic [POINT_INDEX_W-1:0] point_index;
		logic is_new;
		logic table_full;
		logic [UNIQUE_COUNT_W-1:0] unique_count;
	} result_t;

	function automatic coord_t wrap_coord(input logic signed [IN_COORD_W-1:0] raw);
		return COORD_BITS'(raw);
	endfunction

	// The difference is taken one bit wider than a coordinate, so it never overflows.
	function automatic logic within_tol(input coord_t a, input coord_t b,
			input logic [TOL_W-1:0] tol);
		logic signed [DIFF_W-1:0] d;
		logic signed [DIFF_W-1:0] t;
		begin
			d = DIFF_W'(a) - DIFF_W'(b);
			t = DIFF_W'({1'b0, tol});
			return (d <= t) && (d >= -t);
		end
	endfunction

endpackage

// ----- design/tolerant_point_dedup_table.sv -----
// Tolerant point deduplication table: linear scan of a point memory per transfer.
// A transfer reads the point memory at most once per stored entry, stopping at the
// first match; one item is handled at a time. Reset clears the entry count and the
// configuration registers (dims 3, tolerance 0); the memory needs no clearing.
// Results are strobed on done for one cycle.
// Depends on tpdt_pkg.
module tolerant_point_dedup_table (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  tpdt_pkg::point_in_t point,
	output logic done,
	output tpdt_pkg::result_t result,
	input  logic cfg_we,
	input  logic [tpdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpdt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpdt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;
	logic [DIMS_W-1:0] dims_cfg_q;
	logic [TOL_W-1:0] tol_cfg_q;
	logic [DIMS_W-1:0] dims_q;
	logic [TOL_W-1:0] tol_q;
	coord_pt_t pt_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_addr_q;
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	coord_pt_t rd_data_s1;
	logic hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic done_q;
	result_t result_q;

	coord_pt_t mem [MAX_POINTS];
	logic mem_we;

	logic accept;
	logic cmp_ok;
	logic match_now;
	logic issue;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

	assign cmp_ok = within_tol(rd_data_s1.x, pt_q.x, tol_q)
		&& ((dims_q < 2'd2) || within_tol(rd_data_s1.y, pt_q.y, tol_q))
		&& ((dims_q < 2'd3) || within_tol(rd_data_s1.z, pt_q.z, tol_q));
	assign match_now = vld_s1 && cmp_ok;
	assign issue = (state_q == S_SCAN) && (rd_addr_q < count_q) && !match_now;
	assign mem_we = (state_q == S_FIN) && !hit_q && (count_q < CNT_W'(MAX_POINTS));

	// Appends are written in the finish cycle, before any later scan can read them.
	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr_q[IDX_W-1:0]];
		if (mem_we) begin
			mem[count_q[IDX_W-1:0]] <= pt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_cfg_q <= 2'd3;
			tol_cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMS_IN_USE: dims_cfg_q <= cfg_data[DIMS_W-1:0];
				REG_MATCH_TOL:   tol_cfg_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_q.x <= wrap_coord(point.coord_x);
			pt_q.y <= wrap_coord(point.coord_y);
			pt_q.z <= wrap_coord(point.coord_z);
			dims_q <= (dims_cfg_q == '0) ? DIMS_W'(1) : dims_cfg_q;
			tol_q <= tol_cfg_q;
		end
		idx_s1 <= rd_addr_q[IDX_W-1:0];
		if (match_now) begin
			hit_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_addr_q <= '0;
			vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (point.new_mesh) begin
							count_q <= '0;
						end
						rd_addr_q <= '0;
						vld_s1 <= 1'b0;
						hit_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1 <= issue;
					if (issue) begin
						rd_addr_q <= rd_addr_q + CNT_W'(1);
					end
					if (match_now) begin
						hit_q <= 1'b1;
						state_q <= S_FIN;
					end else if (!issue) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q <= 1'b1;
					vld_s1 <= 1'b0;
					if (hit_q) begin
						result_q.point_index <= POINT_INDEX_W'(hit_idx_q);
						result_q.is_new <= 1'b0;
						result_q.table_full <= 1'b0;
						result_q.unique_count <= UNIQUE_COUNT_W'(count_q);
					end else if (mem_we) begin
						count_q <= count_q + CNT_W'(1);
						result_q.point_index <= POINT_INDEX_W'(count_q);
						result_q.is_new <= 1'b1;
						result_q.table_full <= 1'b0;
						result_q.unique_count <= UNIQUE_COUNT_W'(count_q + CNT_W'(1));
					end else begin
						result_q.point_index <= '0;
						result_q.is_new <= 1'b0;
						result_q.table_full <= 1'b1;
						result_q.unique_count <= UNIQUE_COUNT_W'(count_q);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
